// ===== src/cwsr_pkg.sv =====
// Package for the clock working set replacer.
// Holds the sizes, register indexes and controller/datapath interface structs.
// No dependencies.
package cwsr_pkg;

  localparam int MAX_SLOTS  = 16;
  localparam int SLOT_W     = $clog2(MAX_SLOTS);
  localparam int N_W        = $clog2(MAX_SLOTS + 1);
  localparam int PAGE_W     = 20;
  localparam int WS_W       = 5;
  localparam int OUT_SLOT_W = 4;

  localparam int CFG_W      = 20;
  localparam int CFG_IDX_W  = 3;

  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_WS_SIZE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STACK_LOW  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STACK_HIGH = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HEAP_LOW   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_HEAP_HIGH  = 3'd4;

  localparam logic OP_ACCESS = 1'b0;
  localparam logic OP_FAULT  = 1'b1;

  typedef struct packed {
    logic load;
    logic lookup;
    logic hit;
    logic miss;
    logic illegal;
    logic place;
    logic sweep;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic found;
    logic fault;
    logic legal;
    logic empty_found;
    logic used_at_hand;
    logic out_free;
  } stat_t;

endpackage

// ===== src/cwsr_ctrl.sv =====
// Controller for the clock working set replacer.
// Sequences lookup, decision, clock sweep and result hand-off; uses cwsr_pkg.
module cwsr_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  cwsr_pkg::stat_t   stat,
  output cwsr_pkg::cmd_t    cmd
);
  import cwsr_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOOKUP,
    S_DECIDE,
    S_SWEEP,
    S_FINISH
  } state_t;

  state_t state_r;
  logic   in_tready_r;

  assign in_tready = in_tready_r;

  always_comb begin
    cmd = '0;
    unique case (state_r)
      S_IDLE:   cmd.load = in_tvalid & in_tready_r;
      S_LOOKUP: cmd.lookup = 1'b1;
      S_DECIDE: begin
        if (stat.found) begin
          cmd.hit = 1'b1;
        end else if (!stat.fault) begin
          cmd.miss = 1'b1;
        end else if (!stat.legal) begin
          cmd.illegal = 1'b1;
        end else if (stat.empty_found) begin
          cmd.place = 1'b1;
        end
      end
      S_SWEEP:  cmd.sweep = 1'b1;
      S_FINISH: cmd.out_load = stat.out_free;
      default:  cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      in_tready_r <= 1'b1;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_tvalid && in_tready_r) begin
            state_r     <= S_LOOKUP;
            in_tready_r <= 1'b0;
          end
        end
        S_LOOKUP: state_r <= S_DECIDE;
        S_DECIDE: begin
          if (stat.found || !stat.fault || !stat.legal || stat.empty_found) begin
            state_r <= S_FINISH;
          end else begin
            state_r <= S_SWEEP;
          end
        end
        S_SWEEP: begin
          if (!stat.used_at_hand) begin
            state_r <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (stat.out_free) begin
            state_r     <= S_IDLE;
            in_tready_r <= 1'b1;
          end
        end
        default: begin
          state_r     <= S_IDLE;
          in_tready_r <= 1'b1;
        end
      endcase
    end
  end

endmodule

// ===== src/cwsr_datapath.sv =====
// Datapath for the clock working set replacer.
// Holds config registers, slot entries, clock hand and the output register; uses cwsr_pkg.
module cwsr_datapath (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [cwsr_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [cwsr_pkg::CFG_W-1:0]        cfg_wdata,
  input  logic                              in_op,
  input  logic [cwsr_pkg::IN_TDATA_W-1:0]   in_data,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [cwsr_pkg::OUT_TDATA_W-1:0]  out_tdata,
  input  cwsr_pkg::cmd_t                    cmd,
  output cwsr_pkg::stat_t                   stat
);
  import cwsr_pkg::*;

  localparam int CNT_W = (N_W > WS_W) ? N_W : WS_W;
  localparam int SUM_W = N_W + 1;

  logic [WS_W-1:0]   ws_size_r;
  logic [PAGE_W-1:0] stack_lo_r, stack_hi_r, heap_lo_r, heap_hi_r;

  logic [PAGE_W-1:0]    entry_page_r [MAX_SLOTS];
  logic [MAX_SLOTS-1:0] valid_r, used_r, mod_r;
  logic [SLOT_W-1:0]    hand_r;

  logic              op_r, wr_r, pf_r;
  logic [PAGE_W-1:0] pg_r;

  logic              found_r, legal_r, empty_found_r;
  logic [SLOT_W-1:0] found_idx_r, empty_idx_r;

  logic              res_hit_r, res_evict_r, res_vdirty_r, res_illegal_r;
  logic [SLOT_W-1:0] res_slot_r;
  logic [PAGE_W-1:0] res_vpage_r;

  logic                   out_valid_r;
  logic [OUT_TDATA_W-1:0] out_data_r;

  logic [N_W-1:0]       n;
  logic [SLOT_W-1:0]    h_eff;
  logic [MAX_SLOTS-1:0] match;
  logic                 found_c, empty_found_c, legal_c;
  logic [SLOT_W-1:0]    found_idx_c, empty_idx_c;
  logic [SLOT_W-1:0]    rot_idx [MAX_SLOTS];
  logic                 place_en;
  logic [SLOT_W-1:0]    place_idx;

  function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s,
                                                  input logic [N_W-1:0] cnt);
    logic [N_W-1:0] inc;
    inc = N_W'(s) + N_W'(1);
    return (inc == cnt) ? '0 : SLOT_W'(inc);
  endfunction

  always_comb begin
    if (ws_size_r == '0) begin
      n = N_W'(1);
    end else if (CNT_W'(ws_size_r) > CNT_W'(MAX_SLOTS)) begin
      n = N_W'(MAX_SLOTS);
    end else begin
      n = N_W'(ws_size_r);
    end
    h_eff = (N_W'(hand_r) >= n) ? '0 : hand_r;
  end

  always_comb begin
    logic [SUM_W-1:0] sum;
    found_c       = 1'b0;
    found_idx_c   = '0;
    empty_found_c = 1'b0;
    empty_idx_c   = '0;
    for (int i = 0; i < MAX_SLOTS; i++) begin
      match[i] = valid_r[i] && (N_W'(i) < n) && (entry_page_r[i] == pg_r);
      sum = SUM_W'(h_eff) + SUM_W'(i);
      rot_idx[i] = (sum >= SUM_W'(n)) ? SLOT_W'(sum - SUM_W'(n)) : SLOT_W'(sum);
    end
    for (int i = MAX_SLOTS - 1; i >= 0; i--) begin
      if (match[i]) begin
        found_c     = 1'b1;
        found_idx_c = SLOT_W'(i);
      end
      if ((N_W'(i) < n) && !valid_r[rot_idx[i]]) begin
        empty_found_c = 1'b1;
        empty_idx_c   = rot_idx[i];
      end
    end
    legal_c = pf_r || (pg_r >= stack_lo_r && pg_r < stack_hi_r) ||
              (pg_r >= heap_lo_r && pg_r < heap_hi_r);
  end

  assign place_en  = cmd.place | (cmd.sweep & ~used_r[hand_r]);
  assign place_idx = cmd.place ? empty_idx_r : hand_r;

  assign stat.found        = found_r;
  assign stat.fault        = (op_r == OP_FAULT);
  assign stat.legal        = legal_r;
  assign stat.empty_found  = empty_found_r;
  assign stat.used_at_hand = used_r[hand_r];
  assign stat.out_free     = ~out_valid_r | out_tready;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ws_size_r  <= WS_W'(16);
      stack_lo_r <= '0;
      stack_hi_r <= '0;
      heap_lo_r  <= '0;
      heap_hi_r  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_WS_SIZE:    ws_size_r  <= cfg_wdata[WS_W-1:0];
        REG_STACK_LOW:  stack_lo_r <= cfg_wdata[PAGE_W-1:0];
        REG_STACK_HIGH: stack_hi_r <= cfg_wdata[PAGE_W-1:0];
        REG_HEAP_LOW:   heap_lo_r  <= cfg_wdata[PAGE_W-1:0];
        REG_HEAP_HIGH:  heap_hi_r  <= cfg_wdata[PAGE_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= '0;
      used_r      <= '0;
      mod_r       <= '0;
      hand_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.lookup) begin
        hand_r <= h_eff;
      end
      if (cmd.hit) begin
        used_r[found_idx_r] <= 1'b1;
        if (wr_r) begin
          mod_r[found_idx_r] <= 1'b1;
        end
      end
      if (cmd.sweep && used_r[hand_r]) begin
        used_r[hand_r] <= 1'b0;
        hand_r         <= next_slot(hand_r, n);
      end
      if (place_en) begin
        valid_r[place_idx] <= 1'b1;
        used_r[place_idx]  <= 1'b1;
        mod_r[place_idx]   <= wr_r;
        hand_r             <= next_slot(place_idx, n);
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (place_en) begin
      entry_page_r[place_idx] <= pg_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r <= in_op;
      pg_r <= in_data[PAGE_W-1:0];
      wr_r <= in_data[PAGE_W];
      pf_r <= in_data[PAGE_W+1];
    end
    if (cmd.lookup) begin
      found_r       <= found_c;
      found_idx_r   <= found_idx_c;
      legal_r       <= legal_c;
      empty_found_r <= empty_found_c;
      empty_idx_r   <= empty_idx_c;
    end
    if (cmd.hit || cmd.miss || cmd.illegal || place_en) begin
      res_hit_r     <= cmd.hit;
      res_slot_r    <= cmd.hit ? found_idx_r : (place_en ? place_idx : '0);
      res_evict_r   <= cmd.sweep;
      res_vpage_r   <= cmd.sweep ? entry_page_r[hand_r] : '0;
      res_vdirty_r  <= cmd.sweep & mod_r[hand_r];
      res_illegal_r <= cmd.illegal;
    end
    if (cmd.out_load) begin
      out_data_r <= {4'b0000, res_illegal_r, res_vdirty_r, res_vpage_r, res_evict_r,
                     OUT_SLOT_W'(res_slot_r), res_hit_r};
    end
  end

endmodule

// ===== src/clock_working_set_replacer.sv =====
// Top level of the clock working set replacer.
// Joins cwsr_ctrl and cwsr_datapath; uses cwsr_pkg.
//
// Each word goes through lookup and decision to the finish state, which loads the
// output register, when the page is resident, the access misses, the fault is
// illegal or a free slot exists. A fault into a full working set sweeps the clock
// hand in between. With n the slots in use (ws_size held to 1..16), the sweep
// visits up to n + 1 slots, one slot per cycle. The input becomes ready again on
// the edge that loads the output register, so a new word is taken only after the
// last one has reached it, and later while the output stalls. A new word is
// accepted while a finished result still waits in the output register.
module clock_working_set_replacer (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [cwsr_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [cwsr_pkg::CFG_W-1:0]        cfg_wdata,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // page[19:0], is_write[20], in_pagefile[21], zero[23:22]
  input  logic [cwsr_pkg::IN_TDATA_W-1:0]   in_tdata,
  // opcode[0]
  input  logic                              in_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // hit[0], slot[4:1], evicted[5], victim_page[25:6], victim_dirty[26],
  // illegal[27], zero[31:28]
  output logic [cwsr_pkg::OUT_TDATA_W-1:0]  out_tdata
);
  import cwsr_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  cwsr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  cwsr_datapath u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_op      (in_tuser),
    .in_data    (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cmd        (cmd),
    .stat       (stat)
  );

endmodule
